// ----- hdl/mprc_pkg.sv -----
// ----------------------------------------------------------------------------
// mprc_pkg: shared types and helpers for the masked pixel to RGBA converter
// Source format codes, register indexes, reset values, per-channel division
// record and the two arithmetic helpers used by the pipeline.
// ----------------------------------------------------------------------------
package mprc_pkg;

  // source pixel format
  typedef enum logic [1:0] {
    PM_32 = 2'd0,
    PM_24 = 2'd1,
    PM_16 = 2'd2
  } mode_t;

  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_RED_FIELD   = 3'd1,
    CFG_GREEN_FIELD = 3'd2,
    CFG_BLUE_FIELD  = 3'd3,
    CFG_ALPHA_FIELD = 3'd4,
    CFG_SRC_SHIFTS  = 3'd5,
    CFG_DST_SHIFTS  = 3'd6
  } cfg_idx_t;

  localparam logic [1:0]  RST_MODE        = 2'd0;
  localparam logic [31:0] RST_RED_FIELD   = 32'h0000_00FF;
  localparam logic [31:0] RST_GREEN_FIELD = 32'h0000_FF00;
  localparam logic [31:0] RST_BLUE_FIELD  = 32'h00FF_0000;
  localparam logic [31:0] RST_ALPHA_FIELD = 32'hFF00_0000;
  localparam logic [19:0] RST_SHIFTS      = 20'd803072;

  localparam logic [7:0]  OPAQUE = 8'hFF;
  localparam int          NUM_CH = 3;   // red, green, blue
  localparam int          NUM_DIV_ST = 4;
  // extract, multiply, division stages, pack
  localparam int          NUM_ST = NUM_DIV_ST + 3;

  // one color channel in the long-division pipe
  typedef struct packed {
    logic [23:0] rem;
    logic [7:0]  quo;
    logic [31:0] div;
  } dch_t;

  // per-beat sideband carried alongside the division
  typedef struct packed {
    logic [1:0]             mode;
    logic [7:0]             alpha;
    logic [NUM_CH-1:0]      dz;
    logic [NUM_CH-1:0][7:0] fix;
  } side_t;

  // exact x/255 for any x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'h000, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  // one restoring long-division step producing quotient bit k
  function automatic dch_t div_step(input dch_t d, input logic [2:0] k);
    logic [39:0] trial;
    dch_t        r;
    r     = d;
    trial = {8'h00, d.div} << k;
    if ({16'h0000, d.rem} >= trial) begin
      r.rem    = d.rem - trial[23:0];
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- hdl/masked_pixel_to_rgba_converter_unit.sv -----
// ----------------------------------------------------------------------------
// masked_pixel_to_rgba_converter_unit: masked pixel to packed RGBA converter
// Extracts channels by mask and shift, premultiplies (32 bpp), passes (24 bpp)
// or rescales by long division (16 bpp), then packs at destination shifts.
// ----------------------------------------------------------------------------
// Stages: 7 register stages, extract, multiply, four division stages and pack;
//   an unused source format code yields an all-zero rgba_word.
// Throughput: one pixel per cycle unless rgba_stall backs the pipe up; the
//   8-bit restoring 16 bpp rescale spans four stages, two quotient bits each.
// Each stage advances when it is empty or the stage after it moves, so
//   bubbles collapse and pixel_stall rises only when all 7 stages hold a beat.
// Reset clears all valid bits and loads the default register values.
module masked_pixel_to_rgba_converter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mprc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [31:0]                   pixel_word,
  output logic                          rgba_valid,
  input  logic                          rgba_stall,
  output logic [31:0]                   rgba_word,
  output logic                          zero_divisor
);
  import mprc_pkg::*;

  // configuration registers
  logic [1:0]  pixel_mode;
  logic [31:0] red_field;
  logic [31:0] green_field;
  logic [31:0] blue_field;
  logic [31:0] alpha_field;
  logic [19:0] source_shifts;
  logic [19:0] dest_shifts;

  // pipeline control
  logic [NUM_ST-1:0] vld;
  logic [NUM_ST-1:0] vld_next;
  logic [NUM_ST-1:0] en;

  // stage 0: extraction
  logic [1:0]              s0_mode;
  logic [NUM_CH-1:0][15:0] s0_raw;
  logic [NUM_CH-1:0][31:0] s0_div;
  logic [NUM_CH-1:0]       s0_dz;
  logic [7:0]              s0_alpha;

  logic [31:0]             ex_word;
  logic [NUM_CH-1:0][31:0] ex_mask;
  logic [NUM_CH-1:0][4:0]  ex_sh;
  logic [NUM_CH-1:0][15:0] ex_raw;
  logic [NUM_CH-1:0][31:0] ex_div;
  logic [NUM_CH-1:0]       ex_dz;
  logic [31:0]             ex_alpha_raw;
  logic [7:0]              ex_alpha;

  // stage 1: multiply
  side_t             s1_side;
  dch_t [NUM_CH-1:0] s1_dv;
  side_t             mul_side;
  dch_t [NUM_CH-1:0] mul_dv;

  // stages 2..5: division
  side_t             dsd    [NUM_DIV_ST];
  dch_t [NUM_CH-1:0] ddv    [NUM_DIV_ST];
  side_t             sd_in  [NUM_DIV_ST];
  dch_t [NUM_CH-1:0] dv_in  [NUM_DIV_ST];
  dch_t [NUM_CH-1:0] dv_nx  [NUM_DIV_ST];

  // stage 6: pack
  logic [NUM_CH-1:0][7:0] pk_col;
  logic [31:0]            pk_word;
  logic                   pk_zero;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode    <= RST_MODE;
      red_field     <= RST_RED_FIELD;
      green_field   <= RST_GREEN_FIELD;
      blue_field    <= RST_BLUE_FIELD;
      alpha_field   <= RST_ALPHA_FIELD;
      source_shifts <= RST_SHIFTS;
      dest_shifts   <= RST_SHIFTS;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:        pixel_mode    <= cfg_data[1:0];
        CFG_RED_FIELD:   red_field     <= cfg_data;
        CFG_GREEN_FIELD: green_field   <= cfg_data;
        CFG_BLUE_FIELD:  blue_field    <= cfg_data;
        CFG_ALPHA_FIELD: alpha_field   <= cfg_data;
        CFG_SRC_SHIFTS:  source_shifts <= cfg_data[19:0];
        CFG_DST_SHIFTS:  dest_shifts   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // per-stage advance; a stage moves when empty or its successor moves
  always_comb begin
    en[NUM_ST-1] = !vld[NUM_ST-1] || !rgba_stall;
    for (int i = NUM_ST-2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
    vld_next[0] = en[0] ? pixel_valid : vld[0];
    for (int i = 1; i < NUM_ST; i++) begin
      vld_next[i] = en[i] ? vld[i-1] : vld[i];
    end
  end

  assign pixel_stall = !en[0];
  assign rgba_valid  = vld[NUM_ST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  // stage 0: mask and shift out each channel
  always_comb begin
    ex_word    = (pixel_mode == PM_16) ? {16'h0000, pixel_word[15:0]} : pixel_word;
    ex_mask[0] = red_field;
    ex_mask[1] = green_field;
    ex_mask[2] = blue_field;
    for (int c = 0; c < NUM_CH; c++) begin
      ex_sh[c]  = source_shifts[5*c +: 5];
      ex_raw[c] = 16'((ex_word & ex_mask[c]) >> ex_sh[c]);
      ex_div[c] = ex_mask[c] >> ex_sh[c];
      ex_dz[c]  = (ex_div[c] == 32'h0);
    end
    ex_alpha_raw = (pixel_word & alpha_field) >> source_shifts[19:15];
    // alpha only comes from the source in 32 bpp with a nonzero mask
    if (pixel_mode == PM_32 && alpha_field != 32'h0) ex_alpha = ex_alpha_raw[7:0];
    else                                             ex_alpha = OPAQUE;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_mode  <= pixel_mode;
      s0_raw   <= ex_raw;
      s0_div   <= ex_div;
      s0_dz    <= ex_dz;
      s0_alpha <= ex_alpha;
    end
  end

  // stage 1: premultiply by alpha, form raw*255 dividend
  always_comb begin
    mul_side.mode  = s0_mode;
    mul_side.alpha = s0_alpha;
    mul_side.dz    = s0_dz;
    for (int c = 0; c < NUM_CH; c++) begin
      mul_side.fix[c] = div255({8'h00, s0_raw[c][7:0]} * {8'h00, s0_alpha});
      mul_dv[c].rem   = {s0_raw[c], 8'h00} - {8'h00, s0_raw[c]};
      mul_dv[c].quo   = 8'h00;
      mul_dv[c].div   = s0_div[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_side <= mul_side;
      s1_dv   <= mul_dv;
    end
  end

  // stages 2..5: two restoring division steps per stage
  always_comb begin
    sd_in[0] = s1_side;
    dv_in[0] = s1_dv;
    for (int d = 1; d < NUM_DIV_ST; d++) begin
      sd_in[d] = dsd[d-1];
      dv_in[d] = ddv[d-1];
    end
    for (int d = 0; d < NUM_DIV_ST; d++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        dv_nx[d][c] = div_step(div_step(dv_in[d][c], 3'(7 - 2*d)), 3'(6 - 2*d));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < NUM_DIV_ST; d++) begin
      if (en[2+d]) begin
        dsd[d] <= sd_in[d];
        ddv[d] <= dv_nx[d];
      end
    end
  end

  // stage 6: pick channel values by mode and pack
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (dsd[NUM_DIV_ST-1].mode == PM_16) begin
        pk_col[c] = dsd[NUM_DIV_ST-1].dz[c] ? 8'h00 : ddv[NUM_DIV_ST-1][c].quo;
      end else begin
        pk_col[c] = dsd[NUM_DIV_ST-1].fix[c];
      end
    end
    pk_word = ({24'h0, pk_col[0]} << dest_shifts[4:0])
            | ({24'h0, pk_col[1]} << dest_shifts[9:5])
            | ({24'h0, pk_col[2]} << dest_shifts[14:10])
            | ({24'h0, dsd[NUM_DIV_ST-1].alpha} << dest_shifts[19:15]);
    pk_zero = 1'b0;
    unique case (dsd[NUM_DIV_ST-1].mode)
      PM_32, PM_24: ;
      PM_16:   pk_zero = |dsd[NUM_DIV_ST-1].dz;
      default: pk_word = 32'h0;   // unused format code
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[NUM_ST-1]) begin
      rgba_word    <= pk_word;
      zero_divisor <= pk_zero;
    end
  end

  // checks
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (vld == {NUM_ST{1'b1}}))
    else $error("input stalled while a pipeline stage was empty");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_stall) |=> vld[0])
    else $error("accepted beat not captured in first stage");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (rgba_stall && vld == {NUM_ST{1'b1}}) |=> (vld == {NUM_ST{1'b1}}))
    else $error("beat dropped while output stalled");

  a_zero_mode: assert property (@(posedge clk) disable iff (rst)
    (rgba_valid && zero_divisor) |-> (pixel_mode == PM_16))
    else $error("zero divisor flag outside 16 bpp");

endmodule

// ----- sim/masked_pixel_to_rgba_converter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// masked_pixel_to_rgba_converter_unit_tb: self-checking bench for the converter
// Programs the source format, masks and shifts, streams pixel beats through
// the unit under random source gaps and sink stalls, and checks every RGBA
// beat in order against a behavioral converter kept in a scoreboard class.
// ----------------------------------------------------------------------------
module masked_pixel_to_rgba_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mprc_pkg::*;

  // codes outside the package enums
  localparam logic [1:0]           PM_UNUSED      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
  localparam int                   DRAIN_CYCLES   = 12;
  localparam int                   RAND_PHASES    = 9;
  localparam int                   PHASE_BEATS    = 50;

  typedef struct packed {
    logic [31:0] rgba;
    logic        zdiv;
  } rgba_beat_t;

  // --------------------------------------------------------------------------
  // scoreboard: register shadow, pixel converter and in-order result check
  // --------------------------------------------------------------------------
  class rgba_scoreboard;
    logic [1:0]  mode;
    logic [31:0] chan_mask[4];   // red, green, blue, alpha
    logic [19:0] src_sh;
    logic [19:0] dst_sh;
    rgba_beat_t  rgba_expected_q[$];
    int          errors;

    function new();
      mode         = RST_MODE;
      chan_mask[0] = RST_RED_FIELD;
      chan_mask[1] = RST_GREEN_FIELD;
      chan_mask[2] = RST_BLUE_FIELD;
      chan_mask[3] = RST_ALPHA_FIELD;
      src_sh       = RST_SHIFTS;
      dst_sh       = RST_SHIFTS;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        CFG_MODE:        mode = v[1:0];
        CFG_RED_FIELD:   chan_mask[0] = v;
        CFG_GREEN_FIELD: chan_mask[1] = v;
        CFG_BLUE_FIELD:  chan_mask[2] = v;
        CFG_ALPHA_FIELD: chan_mask[3] = v;
        CFG_SRC_SHIFTS:  src_sh = v[19:0];
        CFG_DST_SHIFTS:  dst_sh = v[19:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] extract(logic [31:0] w, int slot);
      return (w & chan_mask[slot]) >> src_sh[5*slot +: 5];
    endfunction

    // 16 bpp rescale to 0..255; a zero divisor yields 0 and raises the flag
    function logic [7:0] rescale(logic [31:0] w, int slot, inout logic zdiv);
      logic [31:0] divisor;
      logic [63:0] num;
      divisor = chan_mask[slot] >> src_sh[5*slot +: 5];
      num     = {32'b0, extract(w, slot)} * 64'd255;
      if (divisor == 0) begin
        zdiv = 1'b1;
        return 8'd0;
      end
      return 8'(num / {32'b0, divisor});
    endfunction

    function rgba_beat_t convert_pixel(logic [31:0] w);
      rgba_beat_t e;
      logic [7:0]  ch[4];
      logic [15:0] prod;
      logic        packs;
      int          i;
      e.rgba = '0;
      e.zdiv = 1'b0;
      packs  = 1'b1;
      case (mode)
        PM_32: begin
          ch[3] = (chan_mask[3] != 0) ? 8'(extract(w, 3)) : OPAQUE;
          for (i = 0; i < 3; i++) begin
            prod  = {8'h00, 8'(extract(w, i))} * {8'h00, ch[3]};
            ch[i] = 8'(prod / 16'd255);
          end
        end
        PM_24: begin
          for (i = 0; i < 3; i++) ch[i] = 8'(extract(w, i));
          ch[3] = OPAQUE;
        end
        PM_16: begin
          for (i = 0; i < 3; i++) ch[i] = rescale({16'b0, w[15:0]}, i, e.zdiv);
          ch[3] = OPAQUE;
        end
        default: packs = 1'b0;
      endcase
      if (packs) begin
        for (i = 0; i < 4; i++) e.rgba |= {24'b0, ch[i]} << dst_sh[5*i +: 5];
      end
      return e;
    endfunction

    function void note_pixel(logic [31:0] w);
      rgba_expected_q.push_back(convert_pixel(w));
    endfunction

    function void check_rgba(logic [31:0] rgba, logic zdiv);
      rgba_beat_t e;
      if (rgba_expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected RGBA beat %h zero_divisor %b", $realtime, rgba, zdiv);
        return;
      end
      e = rgba_expected_q.pop_front();
      if (rgba !== e.rgba || zdiv !== e.zdiv) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch rgba_word exp %h got %h, zero_divisor exp %b got %b",
                   $realtime, e.rgba, rgba, e.zdiv, zdiv);
      end
    endfunction

    function int pending();
      return rgba_expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block inputs
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_stall;
  logic [31:0]          pixel_word = '0;
  logic                 rgba_valid;
  logic                 rgba_stall = 1'b0;
  logic [31:0]          rgba_word;
  logic                 zero_divisor;

  int             send_idle_pct = 0;
  int             stall_pct = 0;
  rgba_scoreboard sb = new();

  always #2 clk = ~clk;

  masked_pixel_to_rgba_converter_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_word   (pixel_word),
    .rgba_valid   (rgba_valid),
    .rgba_stall   (rgba_stall),
    .rgba_word    (rgba_word),
    .zero_divisor (zero_divisor)
  );

  // sink: check accepted beats, then draw the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && rgba_valid && !rgba_stall) sb.check_rgba(rgba_word, zero_divisor);
    rgba_stall <= ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------
  task automatic send_pixel(input logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_word  <= w;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    sb.note_pixel(w);
  endtask

  // stop sending and wait until every beat in flight has come out
  task automatic drain();
    pixel_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // program every register, only once the pipe is empty
  task automatic set_regs(input logic [31:0] md, input logic [31:0] rm,
                          input logic [31:0] gm, input logic [31:0] bm,
                          input logic [31:0] am, input logic [31:0] ss,
                          input logic [31:0] ds);
    drain();
    cfg_write(CFG_MODE, md);
    cfg_write(CFG_RED_FIELD, rm);
    cfg_write(CFG_GREEN_FIELD, gm);
    cfg_write(CFG_BLUE_FIELD, bm);
    cfg_write(CFG_ALPHA_FIELD, am);
    cfg_write(CFG_SRC_SHIFTS, ss);
    cfg_write(CFG_DST_SHIFTS, ds);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random format: mostly contiguous channel fields, some raw masks
  task automatic random_regs();
    logic [31:0] m[4];
    logic [4:0]  sh[4];
    logic [4:0]  dsh[4];
    logic [1:0]  md;
    int          k, roll, wid, pos, span;
    roll = $urandom_range(99);
    md   = (roll < 32) ? PM_32 : (roll < 60) ? PM_24 : (roll < 94) ? PM_16 : PM_UNUSED;
    span = (md == PM_16) ? 16 : 32;
    for (k = 0; k < 4; k++) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        wid   = $urandom_range(1, (md == PM_16) ? 6 : 8);
        pos   = $urandom_range(0, span - wid);
        m[k]  = 32'(((33'h1 << wid) - 33'h1) << pos);
        sh[k] = 5'(pos);
      end else if (roll < 90) begin
        m[k]  = $urandom;
        sh[k] = 5'($urandom_range(31));
      end else begin
        m[k]  = (roll < 95) ? 32'h0 : 32'hFFFF_FFFF;
        sh[k] = 5'($urandom_range(31));
      end
      dsh[k] = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'(8 * $urandom_range(3));
    end
    set_regs({30'($urandom), md}, m[0], m[1], m[2], m[3],
             {12'($urandom), sh[3], sh[2], sh[1], sh[0]},
             {12'($urandom), dsh[3], dsh[2], dsh[1], dsh[0]});
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int p, i;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default format: 32 bpp premultiplied, alpha extremes
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h00FF_FFFF);
    send_pixel(32'h80FF_4020);

    // alpha mask cleared means opaque; a write past the last index is ignored
    set_regs(32'(PM_32), RST_RED_FIELD, RST_GREEN_FIELD, RST_BLUE_FIELD, 32'h0,
             32'(RST_SHIFTS), 32'(RST_SHIFTS));
    send_pixel(32'h1234_5678);
    drain();
    cfg_write(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_pixel(32'hFFC0_8040);

    // 24 bpp with raw fields wider than a byte
    set_regs(32'(PM_24), 32'h0000_0FFF, 32'h00FF_F000, 32'hFFFF_FFFF, RST_ALPHA_FIELD,
             {12'h000, 5'd24, 5'd0, 5'd12, 5'd0}, 32'(RST_SHIFTS));
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hA5A5_A5A5);
    send_pixel(32'h0000_0000);

    // 16 bpp 5-6-5, upper source bits ignored
    set_regs(32'(PM_16), 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, RST_ALPHA_FIELD,
             {12'h000, 5'd0, 5'd0, 5'd5, 5'd11}, 32'(RST_SHIFTS));
    send_pixel(32'h0000_FFFF);
    send_pixel(32'hFFFF_0000);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_8410);

    // 16 bpp zero divisor: empty mask and a shift past the mask
    set_regs(32'(PM_16), 32'h0, 32'h0000_000F, 32'h0000_FFFF, RST_ALPHA_FIELD,
             {12'h000, 5'd0, 5'd0, 5'd4, 5'd0}, 32'(RST_SHIFTS));
    send_pixel(32'h0000_FFFF);
    send_pixel(32'h0000_1234);

    // unused format code
    set_regs(32'hFFFF_FFFF, RST_RED_FIELD, RST_GREEN_FIELD, RST_BLUE_FIELD,
             RST_ALPHA_FIELD, 32'(RST_SHIFTS), 32'(RST_SHIFTS));
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);

    // destination shifts at both ends
    set_regs(32'(PM_24), RST_RED_FIELD, RST_GREEN_FIELD, RST_BLUE_FIELD, RST_ALPHA_FIELD,
             32'(RST_SHIFTS), 32'hFFFF_FFFF);
    send_pixel(32'hFFFF_FFFF);
    set_regs(32'(PM_24), RST_RED_FIELD, RST_GREEN_FIELD, RST_BLUE_FIELD, RST_ALPHA_FIELD,
             32'(RST_SHIFTS), 32'h0);
    send_pixel(32'h00C3_3C81);

    // random phases; idle pattern rotates, first two use extreme registers
    for (p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) set_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      else if (p == 1)
        set_regs(32'(PM_24), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      else random_regs();
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      for (i = 0; i < PHASE_BEATS; i++) begin
        // hold off the source until the pipe runs dry once
        if (p == 2 && i == PHASE_BEATS / 2) drain();
        send_pixel($urandom);
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mprc_pkg.sv
hdl/masked_pixel_to_rgba_converter_unit.sv
sim/masked_pixel_to_rgba_converter_unit_tb.sv
